// ----- rtl/core/dil_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dark interval logger package
// Shared constants and field widths for the dark interval logger.
// ----------------------------------------------------------------------------
package dil_pkg;

  localparam int unsigned HISTORY_DEPTH = 8;
  localparam int unsigned SlotW         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned MinW     = 16;
  localparam int unsigned MinutesW = 17;
  localparam int unsigned CountW   = 4;
  localparam int unsigned TotalW   = 20;
  localparam int unsigned RemW     = 16;
  localparam int unsigned StepW    = 5;
  localparam int unsigned OutW     = 40;

  localparam logic [RemW-1:0]  MS_PER_MINUTE      = 16'd60000;
  localparam logic [MinW-1:0]  MIN_DURATION_RESET = 16'd30;
  localparam logic [StepW-1:0] MIN_DIV_LAST       = 5'(TimeW - 1);
  localparam logic [StepW-1:0] AVG_DIV_LAST       = 5'(TotalW - 1);

endpackage

// ----- rtl/core/dark_interval_logger.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dark interval logger
// Times dark intervals from light events and keeps a ring of their lengths.
//
// Each input transaction carries one light event: tuser is 1 for dark and
// 0 for light, tdata is the millisecond timestamp. Every event yields one
// output transaction with the interval flag, whether a record was added,
// the last logged length in minutes, the mean of the held lengths and the
// record count. The minimum logged length is written through cfg_we_i and
// cfg_wdata_i; the user must write it only while the block is idle, as the
// block itself does not enforce this. One event is handled at a time. An
// event that opens an interval or repeats the current level goes straight
// to the output state. Closing an interval runs a bit-serial divide of the
// 32-bit interval by 60000 and a compare state; an unlogged close then goes
// to the output state, and a logged one adds a write state and a bit-serial
// divide of the 20-bit total by the count. The next event is accepted once
// the result is loaded into the output register. Both divides share one
// shift-and-subtract unit. The output register holds a finished result
// while the receiver stalls, and the next event may be accepted meanwhile.
// Reset empties the log, closes any interval and sets the minimum to 30.
// ----------------------------------------------------------------------------
module dark_interval_logger
  import dil_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [MinW-1:0]  cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] now_ms
  input  logic [TimeW-1:0] s_axis_tdata,
  // [0] is_dark
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [0] in_interval, [1] record_added, [18:2] last_minutes,
  // [35:19] average_minutes, [39:36] stored_count
  output logic [OutW-1:0]  m_axis_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MIN,
    ST_CHECK,
    ST_LOG,
    ST_DIV_AVG,
    ST_OUT
  } state_e;

  state_e             state_q;
  logic               open_q;
  logic               added_q;
  logic [SlotW-1:0]   slot_q;
  logic [CountW-1:0]  count_q;
  logic [TotalW-1:0]  total_q;
  logic [MinW-1:0]    min_q;
  logic [StepW-1:0]   step_q;
  logic               out_valid_q;

  logic [TimeW-1:0]    start_q;
  logic [TimeW-1:0]    dvd_q;
  logic [RemW-1:0]     rem_q;
  logic [RemW-1:0]     dvs_q;
  logic [MinutesW-1:0] rd_q;
  logic [MinutesW-1:0] last_q;
  logic [MinutesW-1:0] avg_q;
  logic [OutW-1:0]     out_data_q;
  logic [MinutesW-1:0] ring_q [HISTORY_DEPTH];

  logic                accept;
  logic                out_free;
  logic [RemW:0]       trial;
  logic                trial_ge;
  logic [RemW-1:0]     rem_d;
  logic [TimeW-1:0]    dvd_d;
  logic [MinutesW-1:0] minutes;
  logic                log_it;
  logic                full;
  logic [TotalW-1:0]   total_d;
  logic [CountW-1:0]   count_d;
  logic [MinutesW-1:0] last_out;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // One restoring division step per cycle; the quotient shifts into dvd_q.
  assign trial    = {rem_q, dvd_q[TimeW-1]};
  assign trial_ge = (trial >= {1'b0, dvs_q});
  assign rem_d    = trial_ge ? RemW'(trial - {1'b0, dvs_q}) : trial[RemW-1:0];
  assign dvd_d    = {dvd_q[TimeW-2:0], trial_ge};

  assign minutes = dvd_q[MinutesW-1:0];
  assign log_it  = (minutes >= {1'b0, min_q});
  assign full    = (count_q == CountW'(HISTORY_DEPTH));
  assign count_d = full ? count_q : count_q + 1'b1;
  assign total_d = total_q - (full ? TotalW'(rd_q) : '0) + TotalW'(minutes);
  assign last_out = (count_q != '0) ? last_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      open_q      <= 1'b0;
      added_q     <= 1'b0;
      slot_q      <= '0;
      count_q     <= '0;
      total_q     <= '0;
      min_q       <= MIN_DURATION_RESET;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_q <= cfg_wdata_i;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            added_q <= 1'b0;
            if (s_axis_tuser && !open_q) begin
              open_q  <= 1'b1;
              state_q <= ST_OUT;
            end else if (!s_axis_tuser && open_q) begin
              open_q  <= 1'b0;
              step_q  <= MIN_DIV_LAST;
              state_q <= ST_DIV_MIN;
            end else begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_DIV_MIN: begin
          if (step_q == '0) begin
            state_q <= ST_CHECK;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        ST_CHECK: begin
          state_q <= log_it ? ST_LOG : ST_OUT;
        end
        ST_LOG: begin
          added_q <= 1'b1;
          total_q <= total_d;
          count_q <= count_d;
          slot_q  <= (slot_q == SlotW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
          step_q  <= AVG_DIV_LAST;
          state_q <= ST_DIV_AVG;
        end
        ST_DIV_AVG: begin
          if (step_q == '0) begin
            state_q <= ST_OUT;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser && !open_q) begin
            start_q <= s_axis_tdata;
          end
          dvd_q <= s_axis_tdata - start_q;
          rem_q <= '0;
          dvs_q <= MS_PER_MINUTE;
        end
      end
      ST_DIV_MIN, ST_DIV_AVG: begin
        dvd_q <= dvd_d;
        rem_q <= rem_d;
      end
      ST_CHECK: begin
        rd_q <= ring_q[slot_q];
      end
      ST_LOG: begin
        ring_q[slot_q] <= minutes;
        last_q         <= minutes;
        dvd_q          <= {total_d, (TimeW - TotalW)'(0)};
        rem_q          <= '0;
        dvs_q          <= RemW'(count_d);
      end
      ST_OUT: begin
        if (out_free) begin
          out_data_q <= {count_q, (count_q != '0) ? avg_q : '0, last_out, added_q, open_q};
        end
      end
      default: begin
      end
    endcase
    if (state_q == ST_DIV_AVG && step_q == '0) begin
      avg_q <= dvd_d[MinutesW-1:0];
    end
  end

endmodule
